### src/grid_ray_wall_intersect_unit_macros.svh
// Assertion macros used by the top-level RTL file, the only one that carries assertions.
`ifndef GRID_RAY_WALL_INTERSECT_UNIT_MACROS_SVH
`define GRID_RAY_WALL_INTERSECT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define GRWI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GRWI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GRWI_ASSERT(name, prop, msg)
`define GRWI_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### src/grwi_pkg.sv
package grwi_pkg;

  localparam int MAP_DIM_DEF    = 8;
  localparam int MAX_STEPS_DEF  = 8;
  localparam int CELL_SHIFT_DEF = 6;
  localparam int ANGLE_BITS_DEF = 12;

  localparam int FRAC_BITS    = 8;
  localparam int POS_W        = 17;
  localparam int OUT_W        = 24;
  localparam int TRIG_W       = 32;
  localparam int COORD_W      = 24;
  localparam int ACC_W        = 64;
  localparam int APB_AW       = 5;
  localparam int APB_DW       = 64;
  localparam int WALLS_W      = 64;
  localparam int DIM_W        = 4;
  localparam int TAYLOR_TERMS = 10;

  localparam logic [1:0] REG_WALLS  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sd8388608;

  typedef struct packed {
    logic load;
    logic step;
  } march_cmd_t;

  typedef struct packed {
    logic                    wall;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } march_stat_t;

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [ACC_W-1:0] v);
    if (v > OUT_MAX) return OUT_W'(OUT_MAX);
    if (v < OUT_MIN) return OUT_W'(OUT_MIN);
    return OUT_W'(v);
  endfunction

  // Shift-subtract division, used only while building constant tables.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table entry for a first-quadrant angle: tan in the upper half, cot below.
  function automatic logic [2*TRIG_W-1:0] trig_entry(int unsigned r, int unsigned abits);
    logic [63:0] x, x2, ts, tc, s, c, tn, ct;
    logic signed [63:0] sv, cv;
    if (r == 0) return '0;
    x  = (64'(r) * 64'd6746518852) >> abits;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    sv = $signed(x);
    cv = $signed(tc);
    for (int n = 1; n < TAYLOR_TERMS; n++) begin
      ts = udiv64((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      tc = udiv64((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
      if ((n & 1) != 0) begin
        sv = sv - $signed(ts);
        cv = cv - $signed(tc);
      end else begin
        sv = sv + $signed(ts);
        cv = cv + $signed(tc);
      end
    end
    s  = (sv < 64'sd1) ? 64'd1 : $unsigned(sv);
    c  = (cv < 64'sd1) ? 64'd1 : $unsigned(cv);
    tn = udiv64(s << 16, c);
    ct = udiv64(c << 16, s);
    return {tn[TRIG_W-1:0], ct[TRIG_W-1:0]};
  endfunction

endpackage

### src/grwi_if.sv
interface grwi_ray_if import grwi_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic [ANGLE_BITS-1:0] angle;

  modport source (output valid, output pos_x, output pos_y, output angle, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input angle, output ready);
endinterface

interface grwi_hit_if import grwi_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] horiz_x;
  logic signed [OUT_W-1:0] horiz_y;
  logic                    horiz_hit;
  logic signed [OUT_W-1:0] vert_x;
  logic signed [OUT_W-1:0] vert_y;
  logic                    vert_hit;

  modport source (output valid, output horiz_x, output horiz_y, output horiz_hit,
                  output vert_x, output vert_y, output vert_hit, input ready);
  modport sink   (input valid, input horiz_x, input horiz_y, input horiz_hit,
                  input vert_x, input vert_y, input vert_hit, output ready);
endinterface

### src/grwi_apb_regs.sv
module grwi_apb_regs import grwi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [WALLS_W-1:0] walls_o,
  output logic [DIM_W-1:0]   width_o,
  output logic [DIM_W-1:0]   height_o
);

  logic [WALLS_W-1:0] walls_q;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [1:0]         idx;
  logic               wr;

  assign idx    = paddr[APB_AW-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walls_q  <= '0;
      width_q  <= DIM_W'(8);
      height_q <= DIM_W'(8);
    end else if (wr) begin
      case (idx)
        REG_WALLS:  walls_q  <= pwdata[WALLS_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WALLS:  prdata = APB_DW'(walls_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign walls_o  = walls_q;
  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

### src/grwi_trig_rom.sv
module grwi_trig_rom import grwi_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int AW = ANGLE_BITS - 2
) (
  input  logic                  clk_i,
  input  logic [AW-1:0]         addr_i,
  output logic [2*TRIG_W-1:0]   data_o
);

  localparam int DEPTH = 1 << AW;

  logic [2*TRIG_W-1:0] rom [DEPTH];
  logic [2*TRIG_W-1:0] data_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [2*TRIG_W-1:0] ENTRY = trig_entry(i, ANGLE_BITS);
    assign rom[i] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

### src/grwi_march_unit.sv
module grwi_march_unit import grwi_pkg::*; #(
  parameter int MAP_DIM    = MAP_DIM_DEF,
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
  input  logic                     clk_i,
  input  march_cmd_t               cmd_i,
  input  logic [POS_W-1:0]         pa_i,
  input  logic [POS_W-1:0]         pb_i,
  input  logic                     neg_i,
  input  logic                     swap_i,
  input  logic signed [TRIG_W:0]   m_i,
  input  logic [WALLS_W-1:0]       walls_i,
  input  logic [DIM_W-1:0]         w_i,
  input  logic [DIM_W-1:0]         h_i,
  output march_stat_t              stat_o
);

  localparam int SH    = FRAC_BITS + CELL_SHIFT;
  localparam int IDX_W = $clog2(MAP_DIM * MAP_DIM);

  logic signed [COORD_W-1:0]        a_q, a_d;
  logic signed [ACC_W-1:0]          p_q, p_d;
  logic signed [COORD_W-1:0]        pa_s, base_s, cell_s, a0, diff;
  logic signed [COORD_W+TRIG_W:0]   prod;
  logic signed [ACC_W-1:0]          mstep, b, a_w, x, y, mx, my, mp;
  logic signed [DIM_W:0]            w_s;
  logic [2*DIM_W-1:0]               wh;

  // The cross coordinate term (pa - a) * m moves by a fixed m * cell per step.
  always_comb begin
    pa_s   = $signed(COORD_W'(pa_i));
    base_s = pa_s & ~COORD_W'((1 << SH) - 1);
    cell_s = $signed(COORD_W'(1 << SH));
    a0     = neg_i ? base_s - COORD_W'(1) : base_s + cell_s;
    diff   = pa_s - a0;
    prod   = diff * m_i;
    mstep  = ACC_W'(m_i) <<< SH;
    a_d    = a_q;
    p_d    = p_q;
    if (cmd_i.load) begin
      a_d = a0;
      p_d = ACC_W'(prod);
    end else if (cmd_i.step) begin
      a_d = neg_i ? a_q - cell_s : a_q + cell_s;
      p_d = neg_i ? p_q + mstep : p_q - mstep;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  always_comb begin
    b   = ACC_W'($signed({1'b0, pb_i})) + (p_q >>> 16);
    a_w = ACC_W'(a_q);
    x   = swap_i ? a_w : b;
    y   = swap_i ? b : a_w;
    mx  = x >>> SH;
    my  = y >>> SH;
    w_s = $signed({1'b0, w_i});
    mp  = my * ACC_W'(w_s) + mx;
    wh  = w_i * h_i;
    stat_o.wall = (mp > 64'sd0) && (mp < $signed(ACC_W'(wh))) && walls_i[mp[IDX_W-1:0]];
    stat_o.x    = sat_out(x);
    stat_o.y    = sat_out(y);
  end

endmodule

### src/grid_ray_wall_intersect_unit.sv
// Each march is a load (one multiply) followed by one step per grid line visited.
// One ray is in flight at a time; the next is taken once the result beat leaves.
// The trig ROM adds a registered read ahead of the marches.
// rst_ni is asynchronous, active low; registers return to walls 0, width 8, height 8.
`include "grid_ray_wall_intersect_unit_macros.svh"
module grid_ray_wall_intersect_unit import grwi_pkg::*; #(
  parameter int MAP_DIM    = MAP_DIM_DEF,
  parameter int MAX_STEPS  = MAX_STEPS_DEF,
  parameter int CELL_SHIFT = CELL_SHIFT_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  grwi_ray_if.sink          ray_in,
  grwi_hit_if.source        hit_out
);

  localparam int AW = ANGLE_BITS - 2;
  localparam int KW = $clog2(MAX_STEPS + 1);
  localparam logic [KW-1:0] K_LAST = KW'(MAX_STEPS);
  localparam logic [ANGLE_BITS-1:0] A_Q1   = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] A_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] A_Q3   = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROM   = 3'd1;
  localparam logic [2:0] ST_HLOAD = 3'd2;
  localparam logic [2:0] ST_HSTEP = 3'd3;
  localparam logic [2:0] ST_VLOAD = 3'd4;
  localparam logic [2:0] ST_VSTEP = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [KW-1:0]           k_q, k_d;
  logic [POS_W-1:0]        px_q, py_q;
  logic [ANGLE_BITS-1:0]   ang_q;
  logic signed [OUT_W-1:0] hx_q, hy_q, vx_q, vy_q;
  logic                    hh_q, vh_q;

  logic [WALLS_W-1:0]      walls;
  logic [DIM_W-1:0]        cfg_w, cfg_h, w_eff, h_eff;
  logic [2*TRIG_W-1:0]     rom_q;
  logic [TRIG_W-1:0]       tn, ct, mag_h, mag_v;
  logic signed [TRIG_W:0]  m_h, m_v, m_sel;
  logic                    q_odd, r_zero, h_deg, v_deg, h_neg, v_neg, phase_v, fin;
  logic                    in_acc, h_store, v_store;
  march_cmd_t              march_cmd;
  march_stat_t             stat;

  grwi_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .walls_o  (walls),
    .width_o  (cfg_w),
    .height_o (cfg_h)
  );

  grwi_trig_rom #(.ANGLE_BITS(ANGLE_BITS)) u_rom (
    .clk_i  (clk_i),
    .addr_i (ang_q[AW-1:0]),
    .data_o (rom_q)
  );

  assign w_eff = (cfg_w > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : cfg_w;
  assign h_eff = (cfg_h > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : cfg_h;

  always_comb begin
    tn     = rom_q[2*TRIG_W-1:TRIG_W];
    ct     = rom_q[TRIG_W-1:0];
    q_odd  = ang_q[ANGLE_BITS-2];
    r_zero = (ang_q[AW-1:0] == '0);
    mag_h  = q_odd ? tn : ct;
    mag_v  = q_odd ? ct : tn;
    if (r_zero) begin
      m_h = '0;
      m_v = '0;
    end else begin
      m_h = q_odd ? $signed({1'b0, mag_h}) : -$signed({1'b0, mag_h});
      m_v = q_odd ? $signed({1'b0, mag_v}) : -$signed({1'b0, mag_v});
    end
    h_deg   = (ang_q == '0) || (ang_q == A_HALF);
    v_deg   = (ang_q == A_Q1) || (ang_q == A_Q3);
    h_neg   = ang_q > A_HALF;
    v_neg   = (ang_q > A_Q1) && (ang_q < A_Q3);
    phase_v = (state_q == ST_VLOAD) || (state_q == ST_VSTEP);
    m_sel   = phase_v ? m_v : m_h;
  end

  grwi_march_unit #(.MAP_DIM(MAP_DIM), .CELL_SHIFT(CELL_SHIFT)) u_march (
    .clk_i   (clk_i),
    .cmd_i   (march_cmd),
    .pa_i    (phase_v ? px_q : py_q),
    .pb_i    (phase_v ? py_q : px_q),
    .neg_i   (phase_v ? v_neg : h_neg),
    .swap_i  (phase_v),
    .m_i     (m_sel),
    .walls_i (walls),
    .w_i     (w_eff),
    .h_i     (h_eff),
    .stat_o  (stat)
  );

  assign in_acc = ray_in.valid && ray_in.ready;
  assign fin    = (k_q == K_LAST) || stat.wall;

  always_comb begin
    state_d        = state_q;
    k_d            = k_q;
    march_cmd.load = 1'b0;
    march_cmd.step = 1'b0;
    h_store        = 1'b0;
    v_store        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_ROM;
      end
      ST_ROM: begin
        state_d = ST_HLOAD;
      end
      ST_HLOAD: begin
        k_d = '0;
        if (h_deg) begin
          state_d = ST_VLOAD;
        end else begin
          march_cmd.load = 1'b1;
          state_d        = ST_HSTEP;
        end
      end
      ST_HSTEP: begin
        if (fin) begin
          h_store = 1'b1;
          state_d = ST_VLOAD;
        end else begin
          march_cmd.step = 1'b1;
          k_d            = k_q + KW'(1);
        end
      end
      ST_VLOAD: begin
        k_d = '0;
        if (v_deg) begin
          state_d = ST_DONE;
        end else begin
          march_cmd.load = 1'b1;
          state_d        = ST_VSTEP;
        end
      end
      ST_VSTEP: begin
        if (fin) begin
          v_store = 1'b1;
          state_d = ST_DONE;
        end else begin
          march_cmd.step = 1'b1;
          k_d            = k_q + KW'(1);
        end
      end
      ST_DONE: begin
        if (hit_out.ready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q  <= ray_in.pos_x;
      py_q  <= ray_in.pos_y;
      ang_q <= ray_in.angle;
    end
    if (state_q == ST_HLOAD && h_deg) begin
      hx_q <= $signed(OUT_W'(px_q));
      hy_q <= $signed(OUT_W'(py_q));
      hh_q <= 1'b0;
    end else if (h_store) begin
      hx_q <= stat.x;
      hy_q <= stat.y;
      hh_q <= stat.wall && (k_q != K_LAST);
    end
    if (state_q == ST_VLOAD && v_deg) begin
      vx_q <= $signed(OUT_W'(px_q));
      vy_q <= $signed(OUT_W'(py_q));
      vh_q <= 1'b0;
    end else if (v_store) begin
      vx_q <= stat.x;
      vy_q <= stat.y;
      vh_q <= stat.wall && (k_q != K_LAST);
    end
  end

  assign ray_in.ready      = (state_q == ST_IDLE);
  assign hit_out.valid     = (state_q == ST_DONE);
  assign hit_out.horiz_x   = hx_q;
  assign hit_out.horiz_y   = hy_q;
  assign hit_out.horiz_hit = hh_q;
  assign hit_out.vert_x    = vx_q;
  assign hit_out.vert_y    = vy_q;
  assign hit_out.vert_hit  = vh_q;

  `GRWI_ASSERT(a_in_out_excl, !(ray_in.ready && hit_out.valid), "ray taken while result pending")
  `GRWI_ASSERT(a_accept_rom, in_acc |=> (state_q == ST_ROM), "accepted ray did not start ROM read")
  `GRWI_ASSERT(a_step_bound, k_q <= K_LAST, "march step count overran")
  `GRWI_ASSERT(a_out_release, (hit_out.valid && hit_out.ready) |=> ray_in.ready, "no return to idle")

endmodule
